// ===== rtl/cwbs_pkg.sv =====
// shared constants, types and sequencer codes of the confidence weighted box smoother
`default_nettype none
package cwbs_pkg;

  localparam int WINDOW       = 4;
  localparam int COORD_BITS   = 12;
  localparam int CONF_BITS    = 8;
  localparam int TYPE_BITS    = 8;
  localparam int NUM_COORDS   = 4;
  localparam int HIST_DEPTH   = WINDOW - 1;
  localparam int CNT_BITS     = $clog2(WINDOW + 1);
  localparam int ENT_BITS     = $clog2(WINDOW);
  localparam int CRD_BITS     = $clog2(NUM_COORDS);
  localparam int DIV_IDX_BITS = $clog2(NUM_COORDS + 1);
  localparam int SUM_EXT      = $clog2(WINDOW);
  localparam int WSUM_BITS    = CONF_BITS + SUM_EXT;
  localparam int PROD_BITS    = COORD_BITS + CONF_BITS;
  localparam int ACC_BITS     = PROD_BITS + SUM_EXT;
  localparam int DQ_BITS      = (COORD_BITS > CONF_BITS) ? COORD_BITS : CONF_BITS;
  localparam int DCNT_BITS    = $clog2(DQ_BITS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CONF_BITS-1:0]  conf_t;
  typedef logic [TYPE_BITS-1:0]  btype_t;

  typedef struct packed {
    coord_t [NUM_COORDS-1:0] c;
    conf_t                   conf;
  } box_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_ZCHK,
    ST_DLOAD,
    ST_DRUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                    idle;
    logic                    clr;
    logic                    mac_en;
    logic [ENT_BITS-1:0]     ent;
    logic [CRD_BITS-1:0]     crd;
    logic                    div_start;
    logic [DIV_IDX_BITS-1:0] div_idx;
    logic                    q_wr;
    logic                    finish;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic hist_full;
    logic wsum_zero;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/cwbs_in_if.sv =====
// input channel carrying one detected box per beat
`default_nettype none
interface cwbs_in_if;
  logic                 valid;
  logic                 ready;
  logic                 start_track;
  cwbs_pkg::coord_t     box_x;
  cwbs_pkg::coord_t     box_y;
  cwbs_pkg::coord_t     box_width;
  cwbs_pkg::coord_t     box_height;
  cwbs_pkg::conf_t      box_confidence;
  cwbs_pkg::btype_t     box_type;

  modport source (
    output valid, start_track, box_x, box_y, box_width, box_height, box_confidence, box_type,
    input  ready
  );
  modport sink (
    input  valid, start_track, box_x, box_y, box_width, box_height, box_confidence, box_type,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/cwbs_out_if.sv =====
// output channel carrying one smoothed box per beat
`default_nettype none
interface cwbs_out_if;
  logic                 valid;
  logic                 ready;
  cwbs_pkg::coord_t     out_x;
  cwbs_pkg::coord_t     out_y;
  cwbs_pkg::coord_t     out_width;
  cwbs_pkg::coord_t     out_height;
  cwbs_pkg::conf_t      out_confidence;
  cwbs_pkg::btype_t     out_type;
  logic                 was_smoothed;

  modport source (
    output valid, out_x, out_y, out_width, out_height, out_confidence, out_type, was_smoothed,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_width, out_height, out_confidence, out_type, was_smoothed,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/cwbs_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module cwbs_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [cwbs_pkg::ACC_BITS-1:0]  dividend_i,
  input  wire logic [cwbs_pkg::WSUM_BITS-1:0] divisor_i,
  output logic                                done_o,
  output logic [cwbs_pkg::DQ_BITS-1:0]        quot_o
);

  logic [cwbs_pkg::WSUM_BITS-1:0] rem_q, rem_d;
  logic [cwbs_pkg::WSUM_BITS-1:0] dvs_q;
  logic [cwbs_pkg::DQ_BITS-1:0]   low_q, low_d;
  logic [cwbs_pkg::DCNT_BITS-1:0] cnt_q;
  logic                           run_q;
  logic                           done_q;
  logic [cwbs_pkg::WSUM_BITS:0]   trial;
  logic                           ge;

  always_comb begin
    trial = {rem_q, low_q[cwbs_pkg::DQ_BITS-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? cwbs_pkg::WSUM_BITS'(trial - {1'b0, dvs_q})
               : cwbs_pkg::WSUM_BITS'(trial);
    low_d = {low_q[cwbs_pkg::DQ_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == cwbs_pkg::DCNT_BITS'(cwbs_pkg::DQ_BITS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= cwbs_pkg::WSUM_BITS'(dividend_i >> cwbs_pkg::DQ_BITS);
      low_q <= dividend_i[cwbs_pkg::DQ_BITS-1:0];
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule
`default_nettype wire

// ===== rtl/cwbs_seq.sv =====
// sequencer stepping the multiply-accumulate walk and the divisions
`default_nettype none
module cwbs_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cwbs_pkg::stat_t stat_i,
  output cwbs_pkg::ctrl_t      ctrl_o
);

  cwbs_pkg::state_e state_q, state_d;
  logic [cwbs_pkg::ENT_BITS-1:0]     ent_q;
  logic [cwbs_pkg::CRD_BITS-1:0]     crd_q;
  logic [cwbs_pkg::DIV_IDX_BITS-1:0] div_q;
  logic mac_last;
  logic div_last;

  assign mac_last = (ent_q == cwbs_pkg::ENT_BITS'(cwbs_pkg::WINDOW - 1)) &&
                    (crd_q == cwbs_pkg::CRD_BITS'(cwbs_pkg::NUM_COORDS - 1));
  assign div_last = div_q == cwbs_pkg::DIV_IDX_BITS'(cwbs_pkg::NUM_COORDS - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      cwbs_pkg::ST_IDLE:  if (stat_i.in_fire) state_d = cwbs_pkg::ST_CHECK;
      cwbs_pkg::ST_CHECK: state_d = stat_i.hist_full ? cwbs_pkg::ST_MAC : cwbs_pkg::ST_DONE;
      cwbs_pkg::ST_MAC:   if (mac_last) state_d = cwbs_pkg::ST_ZCHK;
      cwbs_pkg::ST_ZCHK:  state_d = stat_i.wsum_zero ? cwbs_pkg::ST_DONE : cwbs_pkg::ST_DLOAD;
      cwbs_pkg::ST_DLOAD: state_d = cwbs_pkg::ST_DRUN;
      cwbs_pkg::ST_DRUN: begin
        if (stat_i.div_done) state_d = div_last ? cwbs_pkg::ST_DONE : cwbs_pkg::ST_DLOAD;
      end
      cwbs_pkg::ST_DONE:  if (stat_i.out_free) state_d = cwbs_pkg::ST_IDLE;
      default:            state_d = cwbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.ent       = ent_q;
    ctrl_o.crd       = crd_q;
    ctrl_o.div_idx   = div_q;
    case (state_q)
      cwbs_pkg::ST_IDLE:  ctrl_o.idle      = 1'b1;
      cwbs_pkg::ST_CHECK: ctrl_o.clr       = 1'b1;
      cwbs_pkg::ST_MAC:   ctrl_o.mac_en    = 1'b1;
      cwbs_pkg::ST_DLOAD: ctrl_o.div_start = 1'b1;
      cwbs_pkg::ST_DRUN:  ctrl_o.q_wr      = stat_i.div_done;
      cwbs_pkg::ST_DONE:  ctrl_o.finish    = stat_i.out_free;
      default:            ctrl_o.idle      = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cwbs_pkg::ST_IDLE;
      ent_q   <= '0;
      crd_q   <= '0;
      div_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == cwbs_pkg::ST_CHECK) begin
        ent_q <= '0;
        crd_q <= '0;
      end else if (state_q == cwbs_pkg::ST_MAC) begin
        if (crd_q == cwbs_pkg::CRD_BITS'(cwbs_pkg::NUM_COORDS - 1)) begin
          crd_q <= '0;
          ent_q <= ent_q + 1'b1;
        end else begin
          crd_q <= crd_q + 1'b1;
        end
      end
      if (state_q == cwbs_pkg::ST_ZCHK) begin
        div_q <= '0;
      end else if (state_q == cwbs_pkg::ST_DRUN && stat_i.div_done && !div_last) begin
        div_q <= div_q + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/confidence_weighted_box_smoother_top.sv =====
// top level: box history, shared multiply-accumulate, divider and result register
// a raw pass goes from accept through the check and done states to the result register;
// a smoothed box first takes one multiply-accumulate per coordinate and window entry,
// then four restoring divisions at one bit a cycle
// input ready only while idle, so the next box waits until the last one is finished
// a finished result waits in the output register while the next box is accepted
// reset: history count, track class, sequencer and output valid clear at once
`default_nettype none
module confidence_weighted_box_smoother_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cwbs_in_if.sink    box_i,
  cwbs_out_if.source res_o
);

  cwbs_pkg::ctrl_t ctrl;
  cwbs_pkg::stat_t stat;

  cwbs_pkg::box_t   raw_q;
  cwbs_pkg::box_t   hist_q [cwbs_pkg::HIST_DEPTH];
  cwbs_pkg::box_t   sel_box;
  cwbs_pkg::box_t   res_box;
  logic [cwbs_pkg::CNT_BITS-1:0]  count_q;
  cwbs_pkg::btype_t type_q;
  logic [cwbs_pkg::ACC_BITS-1:0]  acc_q [cwbs_pkg::NUM_COORDS];
  logic [cwbs_pkg::WSUM_BITS-1:0] wsum_q;
  cwbs_pkg::coord_t [cwbs_pkg::NUM_COORDS-1:0] quo_c_q;
  cwbs_pkg::conf_t  sm_conf;
  logic             sm_q;
  logic [cwbs_pkg::PROD_BITS-1:0] prod;
  logic [cwbs_pkg::ACC_BITS-1:0]  div_dividend;
  logic [cwbs_pkg::WSUM_BITS-1:0] div_divisor;
  logic                           div_done;
  logic [cwbs_pkg::DQ_BITS-1:0]   div_quot;

  cwbs_pkg::box_t   out_box_q;
  cwbs_pkg::btype_t out_type_q;
  logic             out_sm_q;
  logic             out_valid_q;

  assign box_i.ready    = ctrl.idle;
  assign stat.in_fire   = box_i.valid && ctrl.idle;
  assign stat.hist_full = count_q >= cwbs_pkg::CNT_BITS'(cwbs_pkg::WINDOW);
  assign stat.wsum_zero = wsum_q == '0;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid_q || res_o.ready;

  cwbs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // window entry zero is the new box, the rest come from history, newest first
  always_comb begin
    sel_box = raw_q;
    for (int k = 0; k < cwbs_pkg::HIST_DEPTH; k++) begin
      if (ctrl.ent == cwbs_pkg::ENT_BITS'(k + 1)) sel_box = hist_q[k];
    end
    prod = cwbs_pkg::PROD_BITS'(sel_box.c[ctrl.crd]) * cwbs_pkg::PROD_BITS'(sel_box.conf);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clr) begin
      for (int j = 0; j < cwbs_pkg::NUM_COORDS; j++) acc_q[j] <= '0;
      wsum_q <= '0;
    end else if (ctrl.mac_en) begin
      acc_q[ctrl.crd] <= acc_q[ctrl.crd] + cwbs_pkg::ACC_BITS'(prod);
      if (ctrl.crd == '0) wsum_q <= wsum_q + cwbs_pkg::WSUM_BITS'(sel_box.conf);
    end
  end

  assign div_dividend = acc_q[ctrl.div_idx[cwbs_pkg::CRD_BITS-1:0]];
  assign div_divisor  = wsum_q;

  // window length is a power of two, so this is a shift
  assign sm_conf = cwbs_pkg::CONF_BITS'(wsum_q / cwbs_pkg::WINDOW);

  cwbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.q_wr) begin
      quo_c_q[ctrl.div_idx[cwbs_pkg::CRD_BITS-1:0]] <= div_quot[cwbs_pkg::COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q <= 1'b0;
    end else if (ctrl.clr) begin
      sm_q <= 1'b0;
    end else if (ctrl.q_wr) begin
      sm_q <= 1'b1;
    end
  end

  assign res_box = sm_q ? cwbs_pkg::box_t'{c: quo_c_q, conf: sm_conf} : raw_q;

  always_ff @(posedge clk_i) begin
    if (stat.in_fire) begin
      raw_q.c[0] <= box_i.box_x;
      raw_q.c[1] <= box_i.box_y;
      raw_q.c[2] <= box_i.box_width;
      raw_q.c[3] <= box_i.box_height;
      raw_q.conf <= box_i.box_confidence;
    end
    if (ctrl.finish) begin
      for (int k = cwbs_pkg::HIST_DEPTH - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
      hist_q[0]  <= res_box;
      out_box_q  <= res_box;
      out_type_q <= type_q;
      out_sm_q   <= sm_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      type_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (stat.in_fire && box_i.start_track) begin
        count_q <= '0;
        type_q  <= box_i.box_type;
      end else if (ctrl.finish && count_q < cwbs_pkg::CNT_BITS'(cwbs_pkg::WINDOW)) begin
        count_q <= count_q + 1'b1;
      end
      if (ctrl.finish) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.out_x          = out_box_q.c[0];
  assign res_o.out_y          = out_box_q.c[1];
  assign res_o.out_width      = out_box_q.c[2];
  assign res_o.out_height     = out_box_q.c[3];
  assign res_o.out_confidence = out_box_q.conf;
  assign res_o.out_type       = out_type_q;
  assign res_o.was_smoothed   = out_sm_q;

endmodule
`default_nettype wire

// ===== tb/sv/box_smoothing_monitor.sv =====
// predicts each smoothed box from the input beats and compares it with the output beats
module box_smoothing_monitor
  import cwbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cwbs_in_if   box_i,
  cwbs_out_if  res_o,
  output int   mismatch_count_o,
  output int   pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t width;
    coord_t height;
    conf_t  conf;
    btype_t cls;
    logic   smoothed;
  } smoothed_box_t;

  box_t          track_hist [HIST_DEPTH];
  int unsigned   hist_len;
  btype_t        track_class;
  smoothed_box_t pending_boxes [$];
  smoothed_box_t want;
  box_t          raw_box;
  int            mismatches;

  // c[0..3] holds x, y, width, height
  function automatic smoothed_box_t smooth_next_box(logic start, box_t raw, btype_t cls);
    smoothed_box_t r;
    box_t          kept;
    logic [31:0]   wsum;
    logic [31:0]   acc [NUM_COORDS];
    if (start) begin
      hist_len    = 0;
      track_class = cls;
    end
    kept       = raw;
    r.smoothed = 1'b0;
    if (hist_len >= WINDOW) begin
      wsum = 32'(raw.conf);
      for (int j = 0; j < NUM_COORDS; j++) acc[j] = 32'(raw.c[j]) * 32'(raw.conf);
      for (int i = 0; i < HIST_DEPTH; i++) begin
        wsum += 32'(track_hist[i].conf);
        for (int j = 0; j < NUM_COORDS; j++)
          acc[j] += 32'(track_hist[i].c[j]) * 32'(track_hist[i].conf);
      end
      if (wsum != 0) begin
        for (int j = 0; j < NUM_COORDS; j++) kept.c[j] = coord_t'(acc[j] / wsum);
        kept.conf  = conf_t'(wsum / WINDOW);
        r.smoothed = 1'b1;
      end
    end
    for (int i = HIST_DEPTH - 1; i > 0; i--) track_hist[i] = track_hist[i-1];
    track_hist[0] = kept;
    if (hist_len < WINDOW) hist_len++;
    r.x      = kept.c[0];
    r.y      = kept.c[1];
    r.width  = kept.c[2];
    r.height = kept.c[3];
    r.conf   = kept.conf;
    r.cls    = track_class;
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hist_len    = 0;
      track_class = '0;
      mismatches  = 0;
      pending_boxes.delete();
    end else begin
      if (res_o.valid && res_o.ready) begin
        if (pending_boxes.size() == 0) begin
          $error("output beat with no box pending");
          mismatches++;
        end else begin
          want = pending_boxes.pop_front();
          compare_field("out_x", want.x, res_o.out_x);
          compare_field("out_y", want.y, res_o.out_y);
          compare_field("out_width", want.width, res_o.out_width);
          compare_field("out_height", want.height, res_o.out_height);
          compare_field("out_confidence", want.conf, res_o.out_confidence);
          compare_field("out_type", want.cls, res_o.out_type);
          compare_field("was_smoothed", want.smoothed, res_o.was_smoothed);
        end
      end
      if (box_i.valid && box_i.ready) begin
        raw_box.c[0] = box_i.box_x;
        raw_box.c[1] = box_i.box_y;
        raw_box.c[2] = box_i.box_width;
        raw_box.c[3] = box_i.box_height;
        raw_box.conf = box_i.box_confidence;
        pending_boxes.push_back(smooth_next_box(box_i.start_track, raw_box, box_i.box_type));
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= pending_boxes.size();
  end

endmodule

// ===== tb/sv/confidence_weighted_box_smoother_top_tb.sv =====
// stimulus, output pacing and verdict for the confidence weighted box smoother
module confidence_weighted_box_smoother_top_tb
  import cwbs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BOXES  = 1850;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 600;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   pending;
  int   burst_left;
  int   boxes_sent;

  cwbs_in_if  box_if ();
  cwbs_out_if res_if ();

  confidence_weighted_box_smoother_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_if),
    .res_o  (res_if)
  );

  box_smoothing_monitor u_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .box_i            (box_if),
    .res_o            (res_if),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    endcase
  endfunction

  // dim tracks are mostly zero weight so the weight sum can vanish
  function automatic conf_t pick_conf(logic dim);
    if (dim) return ($urandom_range(0, 9) < 7) ? conf_t'(0) : conf_t'($urandom_range(0, 3));
    case ($urandom_range(0, 19))
      0, 1: return '0;
      2:    return '1;
      default: return conf_t'($urandom_range(0, (1 << CONF_BITS) - 1));
    endcase
  endfunction

  task automatic offer_box(logic start, coord_t x, coord_t y, coord_t w, coord_t h,
                           conf_t conf, btype_t cls);
    int gap;
    box_if.valid          <= 1'b1;
    box_if.start_track    <= start;
    box_if.box_x          <= x;
    box_if.box_y          <= y;
    box_if.box_width      <= w;
    box_if.box_height     <= h;
    box_if.box_confidence <= conf;
    box_if.box_type       <= cls;
    do @(posedge clk_i); while (!(box_if.valid && box_if.ready));
    boxes_sent++;
    if (burst_left > 0 && boxes_sent < TOTAL_BOXES) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 160) : $urandom_range(1, 40);
      box_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 30);
    end
  endtask

  initial begin : stimulus
    int     track_len;
    logic   dim;
    btype_t cls;
    rst_ni                = 1'b0;
    box_if.valid          = 1'b0;
    box_if.start_track    = 1'b0;
    box_if.box_x          = '0;
    box_if.box_y          = '0;
    box_if.box_width      = '0;
    box_if.box_height     = '0;
    box_if.box_confidence = '0;
    box_if.box_type       = '0;
    burst_left            = $urandom_range(0, 10);
    boxes_sent            = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no track started yet, full scale boxes then a smoothed one
    repeat (4) offer_box(1'b0, '1, '1, '1, '1, '1, 8'h3C);
    offer_box(1'b0, '0, '0, '0, '0, '1, 8'hC3);
    // new track with zero weights, then one box of weight one
    offer_box(1'b1, '0, '0, '0, '0, '0, '1);
    repeat (3) offer_box(1'b0, '1, '1, '1, '1, '0, 8'h11);
    offer_box(1'b0, '1, '0, '1, '0, '0, 8'h22);
    offer_box(1'b0, '1, '0, '1, '0, 8'd1, 8'h33);
    // back to back starts, then mixed weights
    offer_box(1'b1, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 8'd128, 8'hA5);
    offer_box(1'b1, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 8'd1, 8'h5A);
    offer_box(1'b0, '1, '0, 12'd1, 12'd4094, 8'd128, 8'h00);
    offer_box(1'b0, '0, '1, 12'd4094, 12'd1, '1, 8'hFF);
    offer_box(1'b0, 12'd2048, 12'd2047, 12'd100, 12'd3000, 8'd200, 8'h01);
    offer_box(1'b0, '1, '1, '1, '1, '0, 8'h80);
    offer_box(1'b0, '0, '0, '0, '0, 8'd7, 8'h7F);

    while (boxes_sent < TOTAL_BOXES) begin
      track_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      dim       = ($urandom_range(0, 7) == 0);
      cls       = btype_t'($urandom_range(0, 255));
      for (int k = 0; k < track_len && boxes_sent < TOTAL_BOXES; k++) begin
        if ($urandom_range(0, 19) == 0)
          offer_box(1'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), conf_t'($urandom_range(0, 255)),
                    btype_t'($urandom_range(0, 255)));
        else
          offer_box(k == 0, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_conf(dim), (k == 0) ? cls : btype_t'($urandom_range(0, 255)));
      end
    end

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : receiver
    int mode;
    int run_len;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    repeat (800) begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(0, 3) != 0);
    end
    // long hold-off so the block backs up into its input
    repeat (HOLD_CYCLES) begin
      @(posedge clk_i);
      res_if.ready <= 1'b0;
    end
    forever begin
      mode    = $urandom_range(0, 9);
      run_len = $urandom_range(20, 300);
      repeat (run_len) begin
        @(posedge clk_i);
        case (mode)
          0, 1, 2, 3: res_if.ready <= 1'b1;
          4, 5, 6, 7: res_if.ready <= 1'($urandom_range(0, 1));
          8:          res_if.ready <= ($urandom_range(0, 9) == 0);
          default:    res_if.ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((box_if.valid && box_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
